[rtl/pas_pkg.sv]
// Shared types and constants for the pool affinity selector.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package pas_pkg;

    localparam int unsigned SLOT_W   = 3;
    localparam int unsigned SOCKET_W = 8;
    localparam int unsigned USES_W   = 16;
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 8;

    localparam logic [USES_W-1:0] FALLBACK_LIMIT = 16'h8000;
    localparam logic [USES_W-1:0] COUNT_MAX      = 16'hFFFF;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef struct packed {
        logic load;
        logic start;
        logic scan;
        logic cap_hit;
        logic cap_none;
        logic bump;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic done;
        logic have_fb;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[rtl/pas_datapath.sv]
// Datapath of the pool affinity selector: entry storage, scan pipeline, result register.
// Depends on pas_pkg; driven by pas_controller through t_cmd and t_sts.
`default_nettype none

module pas_datapath #(
    parameter int unsigned ENTRIES = 8
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire pas_pkg::t_cmd              i_cmd,
    output pas_pkg::t_sts                   o_sts,
    input  wire [pas_pkg::SLOT_W-1:0]       i_slot,
    input  wire                             i_slot_present,
    input  wire                             i_slot_any,
    input  wire [pas_pkg::SOCKET_W-1:0]     i_slot_socket,
    input  wire [pas_pkg::USES_W-1:0]       i_slot_uses,
    input  wire [pas_pkg::SOCKET_W-1:0]     i_want_socket,
    input  wire                             i_m_ready,
    output logic                            o_m_valid,
    output logic                            o_found,
    output logic [pas_pkg::SLOT_W-1:0]      o_chosen_slot,
    output logic                            o_from_fallback
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
    localparam int unsigned XW    = IDX_W + pas_pkg::SLOT_W;

    logic [ENTRIES-1:0]           r_present;
    logic                         any_mem  [ENTRIES];
    logic [pas_pkg::SOCKET_W-1:0] sock_mem [ENTRIES];
    logic [pas_pkg::USES_W-1:0]   uses_mem [ENTRIES];

    logic                         r_rd_any;
    logic [pas_pkg::SOCKET_W-1:0] r_rd_sock;
    logic [pas_pkg::USES_W-1:0]   r_rd_uses;

    logic [pas_pkg::SOCKET_W-1:0] r_want;
    logic [CNT_W-1:0]             r_rd_idx;
    logic                         r_ev_valid;
    logic [IDX_W-1:0]             r_ev_idx;
    logic [pas_pkg::USES_W-1:0]   r_best;
    logic [IDX_W-1:0]             r_fb_idx;
    logic                         r_have_fb;

    logic                         r_pend_found;
    logic [pas_pkg::SLOT_W-1:0]   r_pend_slot;
    logic                         r_pend_fb;

    logic                         r_out_valid;
    logic                         r_out_found;
    logic [pas_pkg::SLOT_W-1:0]   r_out_slot;
    logic                         r_out_fb;

    logic [XW-1:0]                slot_ext;
    logic                         slot_ok;
    logic [IDX_W-1:0]             wr_idx;
    logic                         rd_in;
    logic [IDX_W-1:0]             rd_addr;
    logic                         ev_take;
    logic                         hit;
    logic                         fb_better;
    logic [pas_pkg::USES_W-1:0]   bumped;
    logic [XW-1:0]                ev_ext;
    logic [XW-1:0]                fb_ext;

    assign slot_ext  = {{IDX_W{1'b0}}, i_slot};
    assign slot_ok   = slot_ext < XW'(ENTRIES);
    assign wr_idx    = slot_ext[IDX_W-1:0];
    assign rd_in     = r_rd_idx < CNT_W'(ENTRIES);
    assign rd_addr   = r_rd_idx[IDX_W-1:0];
    assign ev_take   = r_ev_valid && r_present[r_ev_idx];
    assign hit       = ev_take && !r_rd_any && (r_rd_sock == r_want);
    assign fb_better = ev_take && r_rd_any && (r_rd_uses < r_best);
    assign bumped    = (r_best == pas_pkg::COUNT_MAX) ? r_best
                     : r_best + {{(pas_pkg::USES_W-1){1'b0}}, 1'b1};
    assign ev_ext    = {{pas_pkg::SLOT_W{1'b0}}, r_ev_idx};
    assign fb_ext    = {{pas_pkg::SLOT_W{1'b0}}, r_fb_idx};

    assign o_sts.hit      = hit;
    assign o_sts.done     = !r_ev_valid && !rd_in;
    assign o_sts.have_fb  = r_have_fb;
    assign o_sts.out_free = !r_out_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
        end else if (i_cmd.load && slot_ok) begin
            r_present[wr_idx] <= i_slot_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && slot_ok) begin
            any_mem[wr_idx]  <= i_slot_any;
            sock_mem[wr_idx] <= i_slot_socket;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && slot_ok) begin
            uses_mem[wr_idx] <= i_slot_uses;
        end else if (i_cmd.bump) begin
            uses_mem[r_fb_idx] <= bumped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && rd_in) begin
            r_rd_any  <= any_mem[rd_addr];
            r_rd_sock <= sock_mem[rd_addr];
            r_rd_uses <= uses_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx   <= '0;
            r_ev_valid <= 1'b0;
            r_have_fb  <= 1'b0;
        end else if (i_cmd.start) begin
            r_rd_idx   <= '0;
            r_ev_valid <= 1'b0;
            r_have_fb  <= 1'b0;
        end else if (i_cmd.scan) begin
            if (rd_in) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            r_ev_valid <= rd_in;
            if (fb_better) begin
                r_have_fb <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_want <= i_want_socket;
            r_best <= pas_pkg::FALLBACK_LIMIT;
        end else if (i_cmd.scan) begin
            r_ev_idx <= rd_addr;
            if (fb_better) begin
                r_best   <= r_rd_uses;
                r_fb_idx <= r_ev_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_hit) begin
            r_pend_found <= 1'b1;
            r_pend_slot  <= ev_ext[pas_pkg::SLOT_W-1:0];
            r_pend_fb    <= 1'b0;
        end else if (i_cmd.cap_none) begin
            r_pend_found <= 1'b0;
            r_pend_slot  <= '0;
            r_pend_fb    <= 1'b0;
        end else if (i_cmd.bump) begin
            r_pend_found <= 1'b1;
            r_pend_slot  <= fb_ext[pas_pkg::SLOT_W-1:0];
            r_pend_fb    <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_found <= r_pend_found;
            r_out_slot  <= r_pend_slot;
            r_out_fb    <= r_pend_fb;
        end
    end

    assign o_m_valid       = r_out_valid;
    assign o_found         = r_out_found;
    assign o_chosen_slot   = r_out_slot;
    assign o_from_fallback = r_out_fb;

`ifndef SYNTH
    a_fb_has_candidate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.bump |-> (r_have_fb && (r_best < pas_pkg::FALLBACK_LIMIT)))
        else $error("bump without a fallback candidate below the limit");

    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |-> (!r_out_valid || i_m_ready))
        else $error("result published over an untaken beat");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> ((r_out_slot == '0) && !r_out_fb))
        else $error("not-found beat carries a slot or fallback mark");
`endif

endmodule

`default_nettype wire

[rtl/pas_controller.sv]
// Controller of the pool affinity selector: accepts beats and sequences the scan.
// Depends on pas_pkg; drives pas_datapath through t_cmd and reads t_sts.
`default_nettype none

module pas_controller (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_valid,
    input  wire                 i_kind,
    output logic                o_s_ready,
    output pas_pkg::t_cmd       o_cmd,
    input  wire pas_pkg::t_sts  i_sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BUMP,
        ST_POST
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept    = i_s_valid && (r_state == ST_IDLE);
    assign o_s_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd          = '0;
        n_state        = r_state;
        o_cmd.load     = accept && (i_kind == pas_pkg::KIND_LOAD);
        o_cmd.start    = accept && (i_kind == pas_pkg::KIND_REQUEST);
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.cap_hit = 1'b1;
                    n_state       = ST_POST;
                end else if (i_sts.done) begin
                    if (i_sts.have_fb) begin
                        n_state = ST_BUMP;
                    end else begin
                        o_cmd.cap_none = 1'b1;
                        n_state        = ST_POST;
                    end
                end
            end
            ST_BUMP: begin
                o_cmd.bump = 1'b1;
                n_state    = ST_POST;
            end
            ST_POST: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_scan_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !o_s_ready)
        else $error("input open during scan");

    a_start_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == ST_SCAN))
        else $error("request did not enter scan");

    a_single_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.cap_hit, o_cmd.cap_none, o_cmd.bump, o_cmd.publish}) <= 1)
        else $error("conflicting result commands");
`endif

endmodule

`default_nettype wire

[rtl/pool_affinity_selector.sv]
// Top level of the pool affinity selector: stream ports and field packing.
// Depends on pas_pkg, pas_controller and pas_datapath.
`default_nettype none

// A load beat (tuser = 0) writes one table entry and returns no result; the
// next beat can follow at once. A request beat (tuser = 1) scans the table one
// entry per cycle through a registered read of the entry store. A socket match
// ends the scan; the result goes to a pending register and then to the output
// register. With no match the whole table is scanned, and when an any-socket
// entry is picked its count is bumped before the result is published. The
// result waits while the previous result still waits on the output register.
// The input is closed while a request is in flight.
module pool_affinity_selector #(
    parameter int unsigned ENTRIES = 8
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s_tvalid,
    output logic                           o_s_tready,
    // slot[2:0], slot_present[3], slot_any[4], slot_socket[12:5],
    // slot_uses[28:13], want_socket[36:29], zero[39:37]
    input  wire [pas_pkg::S_DATA_W-1:0]    i_s_tdata,
    // kind[0]
    input  wire                            i_s_tuser,
    output logic                           o_m_tvalid,
    input  wire                            i_m_tready,
    // found[0], chosen_slot[3:1], from_fallback[4], zero[7:5]
    output logic [pas_pkg::M_DATA_W-1:0]   o_m_tdata
);

    pas_pkg::t_cmd               cmd;
    pas_pkg::t_sts               sts;
    logic                        found;
    logic [pas_pkg::SLOT_W-1:0]  chosen_slot;
    logic                        from_fallback;

    pas_controller u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_kind    (i_s_tuser),
        .o_s_ready (o_s_tready),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    pas_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_slot          (i_s_tdata[2:0]),
        .i_slot_present  (i_s_tdata[3]),
        .i_slot_any      (i_s_tdata[4]),
        .i_slot_socket   (i_s_tdata[12:5]),
        .i_slot_uses     (i_s_tdata[28:13]),
        .i_want_socket   (i_s_tdata[36:29]),
        .i_m_ready       (i_m_tready),
        .o_m_valid       (o_m_tvalid),
        .o_found         (found),
        .o_chosen_slot   (chosen_slot),
        .o_from_fallback (from_fallback)
    );

    assign o_m_tdata = {3'b000, from_fallback, chosen_slot, found};

endmodule

`default_nettype wire
